// File: src/dimu_pkg.sv
// Shared types, constants and the per-job operation decoder for the dimuon
// two-track mass block. No dependencies.
package dimu_pkg;

   // Field widths.
   localparam int MOM_W  = 29;
   localparam int MASS_W = 22;
   localparam int OUT_W  = 32;
   localparam int CHG_W  = 2;
   localparam int SLOT_W = 2;
   localparam int CSR_IDX_W = 2;

   // Held momenta: three components for each of the four slots.
   localparam int N_HELD = 12;
   localparam int HELD_IDX_W = $clog2(N_HELD);

   // Result slots: eight energies, then the dimuon mass and nine four-body masses.
   localparam int N_VAL     = 18;
   localparam int JOB_W     = $clog2(N_VAL);
   localparam int N_ENERGY  = 8;
   localparam int DIMU_JOB  = 8;
   localparam int FIRST_E4  = 9;
   localparam int LAST_JOB  = N_VAL - 1;
   localparam int TERM_W    = 2;
   localparam int LAST_TERM = 3;

   // Square root: one result bit per cycle over a 64-bit radicand.
   localparam int RAD_W      = 64;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
   localparam int REM_W      = ROOT_STEPS + 2;

   // Datapath operand and product widths.
   localparam int SRC_W  = 33;
   localparam int OPND_W = 31;
   localparam int PROD_W = 2 * OPND_W;

   // Slot codes.
   localparam logic [SLOT_W-1:0] SLOT_TRACK1 = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_TRACK2 = 2'd3;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] REG_MUON   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KAON   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROTON = 2'd3;
   localparam logic [MASS_W-1:0] MUON_MASS_RST   = 22'd105658;
   localparam logic [MASS_W-1:0] PION_MASS_RST   = 22'd139570;
   localparam logic [MASS_W-1:0] KAON_MASS_RST   = 22'd493677;
   localparam logic [MASS_W-1:0] PROTON_MASS_RST = 22'd938272;

   // Charge weight codes.
   localparam logic [CHG_W-1:0] WEIGHT_PLUS  = 2'b01;
   localparam logic [CHG_W-1:0] WEIGHT_MINUS = 2'b11;

   // Operand sources for the squaring pipeline.
   typedef enum logic [2:0] {
      SRC_MOM,
      SRC_MASS,
      SRC_DIMU,
      SRC_FULL,
      SRC_EMU,
      SRC_E4
   } src_type;

   typedef struct packed {
      logic                  sub;
      logic                  clr;
      src_type               src;
      logic [HELD_IDX_W-1:0] idx;
      logic [1:0]            hyp1;
      logic [1:0]            hyp2;
   } sq_op_type;

   typedef struct packed {
      logic             take;
      logic             sq_issue;
      sq_op_type        sq;
      logic             root_start;
      logic [JOB_W-1:0] dst;
      logic             load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic root_done;
   } dp_status_type;

   // Decode the squared term of a job. Jobs 0-7 are energies, job 8 the
   // dimuon mass, jobs 9-17 the four-body masses (track 1 outer hypothesis).
   function automatic sq_op_type job_op(input logic [JOB_W-1:0] job,
                                        input logic [TERM_W-1:0] term);
      sq_op_type             op;
      logic [1:0]            part;
      logic [1:0]            mass_idx;
      logic [3:0]            e4;
      logic [1:0]            h1;
      op       = '0;
      op.src   = SRC_MOM;
      op.clr   = (term == 2'd0);
      part     = 2'd0;
      mass_idx = 2'd0;
      e4       = 4'(job - JOB_W'(FIRST_E4));
      h1       = (e4 >= 4'd6) ? 2'd2 : ((e4 >= 4'd3) ? 2'd1 : 2'd0);
      if (job < JOB_W'(N_ENERGY)) begin
         if (job == 5'd0) begin
            part = 2'd0;
         end else if (job == 5'd1) begin
            part = 2'd1;
         end else if (job < 5'd5) begin
            part     = 2'd2;
            mass_idx = 2'(job - 5'd1);
         end else begin
            part     = 2'd3;
            mass_idx = 2'(job - 5'd4);
         end
         if (term == 2'(LAST_TERM)) begin
            op.src = SRC_MASS;
            op.idx = HELD_IDX_W'(mass_idx);
         end else begin
            op.src = SRC_MOM;
            op.idx = HELD_IDX_W'({2'b00, part} * 4'd3 + {2'b00, term});
         end
      end else if (job == JOB_W'(DIMU_JOB)) begin
         if (term == 2'd0) begin
            op.src = SRC_EMU;
         end else begin
            op.src = SRC_DIMU;
            op.sub = 1'b1;
            op.idx = HELD_IDX_W'(term - 2'd1);
         end
      end else begin
         op.hyp1 = h1;
         op.hyp2 = 2'(e4 - 4'd3 * {2'b00, h1});
         if (term == 2'd0) begin
            op.src = SRC_E4;
         end else begin
            op.src = SRC_FULL;
            op.sub = 1'b1;
            op.idx = HELD_IDX_W'(term - 2'd1);
         end
      end
      return op;
   endfunction

endpackage

// File: src/dimu_dp.sv
// Datapath of the dimuon mass block: held momenta, mass registers, squaring
// pipeline with accumulator, bit-serial square root and result registers. Uses dimu_pkg.
module dimu_dp
   import dimu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [MASS_W-1:0]        csr_wdata,
   input  logic signed [MOM_W-1:0]  req_mom_x,
   input  logic signed [MOM_W-1:0]  req_mom_y,
   input  logic signed [MOM_W-1:0]  req_mom_z,
   input  logic signed [CHG_W-1:0]  req_charge_sign,
   input  logic [SLOT_W-1:0]        req_slot,
   output logic signed [OUT_W-1:0]  rsp_dimuon_mass,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_k,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_p,
   output logic signed [OUT_W-1:0]  rsp_mass_k_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_k_k,
   output logic signed [OUT_W-1:0]  rsp_mass_k_p,
   output logic signed [OUT_W-1:0]  rsp_mass_p_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_p_k,
   output logic signed [OUT_W-1:0]  rsp_mass_p_p,
   output logic signed [CHG_W-1:0]  rsp_charge_weight
);

   logic signed [MOM_W-1:0]  held_ff [N_HELD];
   logic signed [CHG_W-1:0]  charge1_ff;
   logic signed [CHG_W-1:0]  weight_ff;
   logic [MASS_W-1:0]        mass_ff [4];
   logic signed [OUT_W-1:0]  val_ff [N_VAL];
   logic signed [OUT_W-1:0]  rsp_ff [N_VAL - DIMU_JOB];
   logic signed [CHG_W-1:0]  rsp_weight_ff;

   logic [OPND_W-1:0]        opnd_ff;
   logic                     opnd_v_ff, opnd_sub_ff, opnd_clr_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     prod_v_ff, prod_sub_ff, prod_clr_ff;
   logic signed [RAD_W-1:0]  acc_ff;

   logic [RAD_W-1:0]         rad_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [ROOT_STEPS-1:0]    root_ff;
   logic [ROOT_CNT_W-1:0]    cnt_ff;
   logic                     root_busy_ff;
   logic                     neg_ff;
   logic [JOB_W-1:0]         dst_ff;

   logic signed [SRC_W-1:0]  dsum [3];
   logic signed [SRC_W-1:0]  fsum [3];
   logic signed [SRC_W-1:0]  emu;
   logic signed [SRC_W-1:0]  src_val;
   logic [SRC_W-1:0]         src_mag;
   logic signed [RAD_W-1:0]  prod_s;
   logic signed [RAD_W-1:0]  acc_base;
   logic signed [RAD_W-1:0]  acc_in;
   logic [REM_W+1:0]         rem_sh;
   logic [REM_W+1:0]         trial;
   logic                     ge;
   logic [REM_W-1:0]         rem_in;
   logic [ROOT_STEPS-1:0]    root_in;
   logic                     root_done;
   logic signed [OUT_W-1:0]  root_val;
   logic [HELD_IDX_W-1:0]    base_idx;
   logic                     opposite;

   // Momentum sums over the two muons and over all four particles.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dsum[a] = SRC_W'(held_ff[a]) + SRC_W'(held_ff[3 + a]);
         fsum[a] = dsum[a] + SRC_W'(held_ff[6 + a]) + SRC_W'(held_ff[9 + a]);
      end
      emu = SRC_W'(val_ff[0]) + SRC_W'(val_ff[1]);
   end

   // Operand selection for the squaring pipeline.
   always_comb begin
      case (cmd.sq.src)
         SRC_MOM:  src_val = SRC_W'(held_ff[cmd.sq.idx]);
         SRC_MASS: src_val = signed'(SRC_W'(mass_ff[cmd.sq.idx[1:0]]));
         SRC_DIMU: src_val = dsum[cmd.sq.idx[1:0]];
         SRC_FULL: src_val = fsum[cmd.sq.idx[1:0]];
         SRC_EMU:  src_val = emu;
         SRC_E4:   src_val = emu + SRC_W'(val_ff[JOB_W'(2) + JOB_W'(cmd.sq.hyp1)])
                                 + SRC_W'(val_ff[JOB_W'(5) + JOB_W'(cmd.sq.hyp2)]);
         default:  src_val = '0;
      endcase
      src_mag = src_val[SRC_W-1] ? SRC_W'(-src_val) : SRC_W'(src_val);
   end

   // Accumulate or subtract the squared operand.
   always_comb begin
      prod_s   = signed'(RAD_W'(prod_ff));
      acc_base = prod_clr_ff ? '0 : acc_ff;
      acc_in   = prod_sub_ff ? (acc_base - prod_s) : (acc_base + prod_s);
   end

   // One restoring square-root step.
   always_comb begin
      rem_sh    = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial     = (REM_W + 2)'({root_ff, 2'b01});
      ge        = (rem_sh >= trial);
      rem_in    = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_in   = {root_ff[ROOT_STEPS-2:0], ge};
      root_done = root_busy_ff && (cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1));
      if (neg_ff) begin
         root_val = (root_in > 32'h8000_0000) ? 32'sh8000_0000 : signed'(32'd0 - root_in);
      end else begin
         root_val = root_in[ROOT_STEPS-1] ? 32'sh7FFF_FFFF : signed'(root_in);
      end
   end

   assign status.busy      = opnd_v_ff | prod_v_ff;
   assign status.root_done = root_done;

   // Charge weight of the two tracks.
   assign base_idx = HELD_IDX_W'({2'b00, req_slot} * 4'd3);
   assign opposite = ((charge1_ff == 2'sb01) && req_charge_sign[CHG_W-1]) ||
                     (charge1_ff[CHG_W-1] && (req_charge_sign == 2'sb01));

   // Control registers: configuration, charge, pipeline valids, root sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff[REG_MUON]   <= MUON_MASS_RST;
         mass_ff[REG_PION]   <= PION_MASS_RST;
         mass_ff[REG_KAON]   <= KAON_MASS_RST;
         mass_ff[REG_PROTON] <= PROTON_MASS_RST;
         charge1_ff   <= '0;
         opnd_v_ff    <= 1'b0;
         prod_v_ff    <= 1'b0;
         root_busy_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mass_ff[csr_index] <= csr_wdata;
         end
         if (cmd.take && (req_slot == SLOT_TRACK1)) begin
            charge1_ff <= req_charge_sign;
         end
         opnd_v_ff <= cmd.sq_issue;
         prod_v_ff <= opnd_v_ff;
         if (cmd.root_start) begin
            root_busy_ff <= 1'b1;
         end else if (root_done) begin
            root_busy_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         held_ff[base_idx]                  <= req_mom_x;
         held_ff[base_idx + HELD_IDX_W'(1)] <= req_mom_y;
         held_ff[base_idx + HELD_IDX_W'(2)] <= req_mom_z;
         if (req_slot == SLOT_TRACK2) begin
            weight_ff <= opposite ? WEIGHT_PLUS : WEIGHT_MINUS;
         end
      end
      opnd_ff     <= src_mag[OPND_W-1:0];
      opnd_sub_ff <= cmd.sq.sub;
      opnd_clr_ff <= cmd.sq.clr;
      prod_ff     <= opnd_ff * opnd_ff;
      prod_sub_ff <= opnd_sub_ff;
      prod_clr_ff <= opnd_clr_ff;
      if (prod_v_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.root_start) begin
         rad_ff  <= acc_ff[RAD_W-1] ? RAD_W'(-acc_ff) : RAD_W'(acc_ff);
         neg_ff  <= acc_ff[RAD_W-1];
         dst_ff  <= cmd.dst;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (root_busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff + ROOT_CNT_W'(1);
      end
      if (root_done) begin
         val_ff[dst_ff] <= root_val;
      end
      if (cmd.load_rsp) begin
         for (int i = 0; i < N_VAL - DIMU_JOB; i++) begin
            rsp_ff[i] <= val_ff[DIMU_JOB + i];
         end
         rsp_weight_ff <= weight_ff;
      end
   end

   assign rsp_dimuon_mass   = rsp_ff[0];
   assign rsp_mass_pi_pi    = rsp_ff[1];
   assign rsp_mass_pi_k     = rsp_ff[2];
   assign rsp_mass_pi_p     = rsp_ff[3];
   assign rsp_mass_k_pi     = rsp_ff[4];
   assign rsp_mass_k_k      = rsp_ff[5];
   assign rsp_mass_k_p      = rsp_ff[6];
   assign rsp_mass_p_pi     = rsp_ff[7];
   assign rsp_mass_p_k      = rsp_ff[8];
   assign rsp_mass_p_p      = rsp_ff[9];
   assign rsp_charge_weight = rsp_weight_ff;

endmodule

// File: src/dimu_ctrl.sv
// Controller of the dimuon mass block: accepts beats, steps through the
// eighteen square-root jobs and hands the result beat out. Uses dimu_pkg.
module dimu_ctrl
   import dimu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SLOT_W-1:0]   req_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dp_cmd_type          cmd,
   input  dp_status_type       status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DRAIN,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [JOB_W-1:0]    job_ff;
   logic [TERM_W-1:0]   term_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Commands to the datapath.
   always_comb begin
      cmd            = '0;
      cmd.sq         = job_op(job_ff, term_ff);
      cmd.dst        = job_ff;
      cmd.take       = req_valid && (state_ff == ST_IDLE);
      cmd.sq_issue   = (state_ff == ST_SQUARE);
      cmd.root_start = (state_ff == ST_DRAIN) && !status.busy;
      cmd.load_rsp   = (state_ff == ST_FINISH) && out_free;
   end

   // State, job counters and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= '0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result beat replaces the one leaving in the same cycle.
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_slot == SLOT_TRACK2)) begin
                  job_ff   <= '0;
                  term_ff  <= '0;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               term_ff <= term_ff + TERM_W'(1);
               if (term_ff == TERM_W'(LAST_TERM)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!status.busy) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (status.root_done) begin
                  if (job_ff == JOB_W'(LAST_JOB)) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     job_ff   <= job_ff + JOB_W'(1);
                     term_ff  <= '0;
                     state_ff <= ST_SQUARE;
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: src/dimuon_two_track_mass_hypotheses.sv
// Top level of the dimuon plus two-track invariant mass block.
// Instantiates dimu_ctrl and dimu_dp; uses dimu_pkg.
//
// Beats for slots 0, 1 and 2 are stored as they are taken. A slot 3 beat
// starts eighteen jobs on one shared squaring pipeline and one square-root
// unit that yields a result bit per cycle. Each job runs four squared terms,
// a pipeline drain and root load, and 32 root steps whose last one writes the
// value back. No new beat is taken until all eighteen jobs are done. The
// result beat is held in its own register, so new beats are taken while it
// waits. Mass registers may be written only while the block is idle.
module dimuon_two_track_mass_hypotheses
   import dimu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [MASS_W-1:0]        csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [MOM_W-1:0]  req_mom_x,
   input  logic signed [MOM_W-1:0]  req_mom_y,
   input  logic signed [MOM_W-1:0]  req_mom_z,
   input  logic signed [CHG_W-1:0]  req_charge_sign,
   input  logic [SLOT_W-1:0]        req_slot,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_dimuon_mass,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_k,
   output logic signed [OUT_W-1:0]  rsp_mass_pi_p,
   output logic signed [OUT_W-1:0]  rsp_mass_k_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_k_k,
   output logic signed [OUT_W-1:0]  rsp_mass_k_p,
   output logic signed [OUT_W-1:0]  rsp_mass_p_pi,
   output logic signed [OUT_W-1:0]  rsp_mass_p_k,
   output logic signed [OUT_W-1:0]  rsp_mass_p_p,
   output logic signed [CHG_W-1:0]  rsp_charge_weight
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   dimu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_slot  (req_slot),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage.
   dimu_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mom_x         (req_mom_x),
      .req_mom_y         (req_mom_y),
      .req_mom_z         (req_mom_z),
      .req_charge_sign   (req_charge_sign),
      .req_slot          (req_slot),
      .rsp_dimuon_mass   (rsp_dimuon_mass),
      .rsp_mass_pi_pi    (rsp_mass_pi_pi),
      .rsp_mass_pi_k     (rsp_mass_pi_k),
      .rsp_mass_pi_p     (rsp_mass_pi_p),
      .rsp_mass_k_pi     (rsp_mass_k_pi),
      .rsp_mass_k_k      (rsp_mass_k_k),
      .rsp_mass_k_p      (rsp_mass_k_p),
      .rsp_mass_p_pi     (rsp_mass_p_pi),
      .rsp_mass_p_k      (rsp_mass_p_k),
      .rsp_mass_p_p      (rsp_mass_p_p),
      .rsp_charge_weight (rsp_charge_weight)
   );

endmodule

// File: dv/dimu_mass_checker.sv
// Checker for the dimuon two-track mass block: watches the request and
// response channels, predicts each event's masses and compares them.
// Depends on dimu_pkg for widths and codes.
module dimu_mass_checker
   import dimu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [MASS_W-1:0]        csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [MOM_W-1:0]  req_mom_x,
   input  logic signed [MOM_W-1:0]  req_mom_y,
   input  logic signed [MOM_W-1:0]  req_mom_z,
   input  logic signed [CHG_W-1:0]  req_charge_sign,
   input  logic [SLOT_W-1:0]        req_slot,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [OUT_W-1:0]  rsp_dimuon_mass,
   input  logic signed [OUT_W-1:0]  rsp_mass_pi_pi,
   input  logic signed [OUT_W-1:0]  rsp_mass_pi_k,
   input  logic signed [OUT_W-1:0]  rsp_mass_pi_p,
   input  logic signed [OUT_W-1:0]  rsp_mass_k_pi,
   input  logic signed [OUT_W-1:0]  rsp_mass_k_k,
   input  logic signed [OUT_W-1:0]  rsp_mass_k_p,
   input  logic signed [OUT_W-1:0]  rsp_mass_p_pi,
   input  logic signed [OUT_W-1:0]  rsp_mass_p_k,
   input  logic signed [OUT_W-1:0]  rsp_mass_p_p,
   input  logic signed [CHG_W-1:0]  rsp_charge_weight,
   output int                       fail_count,
   output int                       pending_events,
   output int                       events_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [OUT_W-1:0] mass [10];
      logic signed [CHG_W-1:0] weight;
   } event_masses_type;

   event_masses_type       mass_queue [$];
   logic [MASS_W-1:0]      mass_reg [4];
   longint                 mom_store [9];
   longint                 track1_charge;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned square(longint v);
      longint unsigned a;
      a = (v < 0) ? -v : v;
      return a * a;
   endfunction

   function automatic longint unsigned particle_energy(longint px, longint py, longint pz,
                                                       longint unsigned m);
      return floor_root(square(px) + square(py) + square(pz) + m * m);
   endfunction

   // Signed mass: a negative mass squared yields minus the root of its size.
   function automatic logic signed [OUT_W-1:0] signed_mass(longint unsigned e, longint px,
                                                           longint py, longint pz);
      longint unsigned esq;
      longint unsigned psq;
      longint unsigned r;
      esq = e * e;
      psq = square(px) + square(py) + square(pz);
      if (esq >= psq) begin
         r = floor_root(esq - psq);
         if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
         return OUT_W'(r);
      end
      r = floor_root(psq - esq);
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      return OUT_W'(-r);
   endfunction

   // Register writes and accepted request beats update the predictor.
   always @(posedge clock) begin
      longint              p [3];
      longint              c;
      longint unsigned     emu;
      longint unsigned     et1 [3];
      longint unsigned     et2 [3];
      longint              sx, sy, sz;
      event_masses_type    ev;
      if (reset) begin
         mass_reg[0]   <= MUON_MASS_RST;
         mass_reg[1]   <= PION_MASS_RST;
         mass_reg[2]   <= KAON_MASS_RST;
         mass_reg[3]   <= PROTON_MASS_RST;
         track1_charge  = 0;
         foreach (mom_store[i]) mom_store[i] = 0;
      end else begin
         if (csr_we) mass_reg[csr_index] <= csr_wdata;
         if (req_valid && req_ready) begin
            p[0] = req_mom_x;
            p[1] = req_mom_y;
            p[2] = req_mom_z;
            c    = req_charge_sign;
            if (req_slot != SLOT_TRACK2) begin
               for (int i = 0; i < 3; i++) mom_store[req_slot * 3 + i] = p[i];
               if (req_slot == SLOT_TRACK1) track1_charge = c;
            end else begin
               emu = particle_energy(mom_store[0], mom_store[1], mom_store[2], mass_reg[0])
                   + particle_energy(mom_store[3], mom_store[4], mom_store[5], mass_reg[0]);
               sx = mom_store[0] + mom_store[3];
               sy = mom_store[1] + mom_store[4];
               sz = mom_store[2] + mom_store[5];
               ev.mass[0] = signed_mass(emu, sx, sy, sz);
               for (int i = 0; i < 3; i++) begin
                  et1[i] = particle_energy(mom_store[6], mom_store[7], mom_store[8],
                                           mass_reg[i+1]);
                  et2[i] = particle_energy(p[0], p[1], p[2], mass_reg[i+1]);
               end
               sx += mom_store[6] + p[0];
               sy += mom_store[7] + p[1];
               sz += mom_store[8] + p[2];
               for (int i = 0; i < 3; i++)
                  for (int j = 0; j < 3; j++)
                     ev.mass[1 + 3*i + j] = signed_mass(emu + et1[i] + et2[j], sx, sy, sz);
               ev.weight = ((track1_charge > 0 && c < 0) || (track1_charge < 0 && c > 0))
                         ? WEIGHT_PLUS : WEIGHT_MINUS;
               mass_queue.push_back(ev);
            end
         end
      end
   end

   // Each response beat is compared with the oldest predicted event.
   always @(posedge clock) begin
      event_masses_type        ev;
      logic signed [OUT_W-1:0] got [10];
      string                   names [10];
      int                      errs;
      names = '{"dimuon_mass", "mass_pi_pi", "mass_pi_k", "mass_pi_p", "mass_k_pi",
                "mass_k_k", "mass_k_p", "mass_p_pi", "mass_p_k", "mass_p_p"};
      errs  = 0;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_dimuon_mass, rsp_mass_pi_pi, rsp_mass_pi_k, rsp_mass_pi_p,
                 rsp_mass_k_pi, rsp_mass_k_k, rsp_mass_k_p, rsp_mass_p_pi,
                 rsp_mass_p_k, rsp_mass_p_p};
         events_seen <= events_seen + 1;
         if (mass_queue.size() == 0) begin
            $error("response beat with no event pending");
            errs++;
         end else begin
            ev = mass_queue.pop_front();
            for (int i = 0; i < 10; i++)
               if (got[i] !== ev.mass[i]) begin
                  $error("%s: expected %0d, got %0d", names[i], ev.mass[i], got[i]);
                  errs++;
               end
            if (rsp_charge_weight !== ev.weight) begin
               $error("charge_weight: expected %0d, got %0d", ev.weight, rsp_charge_weight);
               errs++;
            end
         end
         fail_count <= fail_count + errs;
      end
   end

   initial begin
      fail_count  = 0;
      events_seen = 0;
   end

   assign pending_events = mass_queue.size();
endmodule

// File: dv/testbench.sv
// Testbench top for the dimuon two-track mass block: drives clock, reset,
// mass registers and event beats, and reports the verdict.
// Depends on dimu_pkg, dimu_mass_checker and the block itself.
module testbench;
   import dimu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 1000;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [MASS_W-1:0]       csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [MOM_W-1:0] req_mom_x, req_mom_y, req_mom_z;
   logic signed [CHG_W-1:0] req_charge_sign;
   logic [SLOT_W-1:0]       req_slot;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [OUT_W-1:0] rsp_dimuon_mass, rsp_mass_pi_pi, rsp_mass_pi_k, rsp_mass_pi_p;
   logic signed [OUT_W-1:0] rsp_mass_k_pi, rsp_mass_k_k, rsp_mass_k_p;
   logic signed [OUT_W-1:0] rsp_mass_p_pi, rsp_mass_p_k, rsp_mass_p_p;
   logic signed [CHG_W-1:0] rsp_charge_weight;
   int                      fail_count;
   int                      pending_events;
   int                      events_seen;
   int                      beats_sent;
   bit                      hold_off;

   dimuon_two_track_mass_hypotheses i_dut (.*);

   dimu_mass_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls, quiet stretches, and one long hold-off.
   initial begin
      int mode;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         mode = (events_seen / 40) % 3;
         rsp_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // One beat: hold valid until accepted, then a random gap outside bursts.
   task automatic send_track(input logic [SLOT_W-1:0] slot, input logic signed [MOM_W-1:0] x,
                             input logic signed [MOM_W-1:0] y,
                             input logic signed [MOM_W-1:0] z,
                             input logic signed [CHG_W-1:0] q, input bit gap);
      req_valid       <= 1'b1;
      req_slot        <= slot;
      req_mom_x       <= x;
      req_mom_y       <= y;
      req_mom_z       <= z;
      req_charge_sign <= q;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (gap) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic signed [MOM_W-1:0] rand_mom();
      case ($urandom_range(0, 5))
         0: return $signed(MOM_W'($urandom));
         1: return -(MOM_W'(1) <<< 28);
         2: return MOM_W'(268435455);
         default: return MOM_W'($signed($urandom_range(0, 20000000)) - 10000000);
      endcase
   endfunction

   task automatic send_event(input bit gap);
      logic [SLOT_W-1:0] order [4];
      order = '{0, 1, 2, 3};
      if ($urandom_range(0, 9) == 0) order[$urandom_range(0, 2)] = 2'($urandom_range(0, 2));
      for (int i = 0; i < 4; i++)
         send_track(order[i], rand_mom(), rand_mom(), rand_mom(),
                    CHG_W'($urandom_range(0, 3)), gap);
   endtask

   // Waits on the clock first so the checker has seen the last accepted beat.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mass(input logic [CSR_IDX_W-1:0] idx, input logic [MASS_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic signed [MOM_W-1:0] mn, mx;
      bit                      burst;
      int                      left;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_MUON;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_slot = '0;
      req_mom_x = '0;
      req_mom_y = '0;
      req_mom_z = '0;
      req_charge_sign = '0;
      hold_off = 1'b0;
      beats_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      mn = -(MOM_W'(1) <<< 28);
      mx = MOM_W'(268435455);

      // Directed: extremes, at rest, all charge codes, muon charge ignored.
      send_track(0, 0, 0, 0, 1, 1);
      send_track(1, 0, 0, 0, -1, 1);
      send_track(2, 0, 0, 0, 1, 1);
      send_track(3, 0, 0, 0, -2, 1);
      send_track(0, mx, mx, mx, 0, 0);
      send_track(1, mn, mn, mn, 0, 0);
      send_track(2, mx, mn, mx, -1, 0);
      send_track(3, mn, mx, mn, 1, 0);
      send_track(0, mx, mx, mx, 0, 0);
      send_track(1, mx, mx, mx, 0, 0);
      send_track(2, mx, mx, mx, -2, 0);
      send_track(3, mx, mx, mx, 1, 0);
      // Repeated and out-of-order slots.
      send_track(2, 1000, -5, 7, 0, 1);
      send_track(0, -300, 2, 9, 1, 1);
      send_track(0, 123456, 0, -9, 1, 1);
      send_track(3, 5, 5, 5, 0, 1);
      send_track(3, -7, 9, 11, 1, 1);
      req_valid <= 1'b0;

      // Phases over mass settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         for (int r = 0; r < 4; r++)
            write_mass(CSR_IDX_W'(r), (phase == 0) ? 22'd0 :
                       (phase == 1) ? 22'h3FFFFF : MASS_W'($urandom));
         if (phase == 5) begin
            write_mass(REG_MUON, MUON_MASS_RST);
            write_mass(REG_PION, PION_MASS_RST);
            write_mass(REG_KAON, KAON_MASS_RST);
            write_mass(REG_PROTON, PROTON_MASS_RST);
         end
         if (phase == 2) hold_off = 1'b1;
         left = 80;
         while (left > 0) begin
            burst = $urandom_range(0, 1);
            for (int b = $urandom_range(1, 6); b > 0 && left > 0; b--) begin
               if ($urandom_range(0, 15) == 0)
                  send_track(2'($urandom_range(0, 3)), rand_mom(), rand_mom(), rand_mom(),
                             CHG_W'($urandom), !burst);
               else
                  send_event(!burst);
               left--;
            end
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
      wait_idle();
      $display("testbench: %0d beats sent, %0d events checked over six mass settings",
               beats_sent, events_seen);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #30000000;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
